// ===== rtl/pfx_pkg.sv =====
// Shared types and constants for the prefix code table decoder.
`timescale 1ns / 1ps
`default_nettype none
package pfx_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SCNT_W  = 9;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned RUN_MAX = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

    localparam logic REG_SYMBOL_COUNT  = 1'b0;
    localparam logic REG_TOTAL_SYMBOLS = 1'b1;

    typedef enum logic [1:0] {
        K_NOP,
        K_LOAD,
        K_DATA,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [SYM_W-1:0]   sym;
        logic [LEN_W-1:0]   len;
        logic [CODE_W-1:0]  code;
        logic [BYTE_W-1:0]  data_byte;
    } t_op;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
        logic             code_error;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_CMP,
        S_RUN,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/pfx_in_if.sv =====
// Input channel: one command beat per item.
`timescale 1ns / 1ps
`default_nettype none
interface pfx_in_if;
    import pfx_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    entry_index;
    logic [SYM_W-1:0]    entry_symbol;
    logic [LEN_W-1:0]    entry_length;
    logic [CODE_W-1:0]   entry_code;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, command, entry_index, entry_symbol, entry_length,
                    entry_code, data_byte, input ready);
    modport sink   (input valid, command, entry_index, entry_symbol, entry_length,
                    entry_code, data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfx_out_if.sv =====
// Output channel: one decoded result per beat.
`timescale 1ns / 1ps
`default_nettype none
interface pfx_out_if;
    import pfx_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done_res;
    logic             code_error;

    modport source (output valid, symbol, last, done_res, code_error, input ready);
    modport sink   (input valid, symbol, last, done_res, code_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfx_front.sv =====
// Front end: accepts input beats, classifies them and drops those with no effect.
`timescale 1ns / 1ps
`default_nettype none
module pfx_front
    import pfx_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256
) (
    pfx_in_if.sink           i_in,
    input  wire logic [SCNT_W-1:0] i_symbol_count,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_op              o_q_data
);
    logic  single_mode;
    logic  idx_ok;
    t_kind kind;

    assign single_mode = (i_symbol_count == SCNT_W'(1));
    assign idx_ok      = ({1'b0, i_in.entry_index} < (IDX_W + 1)'(MAX_ENTRIES));

    always_comb begin
        unique case (i_in.command)
            CMD_LOAD: kind = idx_ok ? K_LOAD : K_NOP;
            CMD_DATA: kind = single_mode ? K_NOP : K_DATA;
            CMD_RUN:  kind = single_mode ? K_RUN : K_NOP;
            default:  kind = K_NOP;
        endcase
    end

    assign i_in.ready = !i_q_full;

    // Beats that cannot produce results or change state never enter the queue.
    assign o_q_push = i_in.valid && !i_q_full && (kind != K_NOP);

    assign o_q_data.kind      = kind;
    assign o_q_data.idx       = i_in.entry_index;
    assign o_q_data.sym       = i_in.entry_symbol;
    assign o_q_data.len       = i_in.entry_length;
    assign o_q_data.code      = i_in.entry_code;
    assign o_q_data.data_byte = i_in.data_byte;
endmodule
`default_nettype wire

// ===== rtl/pfx_queue.sv =====
// Two-entry queue between the front end and the decode engine.
`timescale 1ns / 1ps
`default_nettype none
module pfx_queue
    import pfx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_op       i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_op       o_data
);
    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfx_back.sv =====
// Decode engine: table memory, bit-serial code accumulator and sequential table scan.
`timescale 1ns / 1ps
`default_nettype none
module pfx_back
    import pfx_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES   = 256,
    parameter int unsigned MAX_CODE_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  t_op                       i_q_data,
    output logic                      o_q_pop,
    input  wire logic [SCNT_W-1:0]    i_symbol_count,
    input  wire logic [TOTAL_W-1:0]   i_total_symbols,
    pfx_out_if.source                 o_out
);
    localparam int unsigned AW   = $clog2(MAX_ENTRIES);
    localparam int unsigned CNTW = $clog2(MAX_CODE_BITS + 1);
    localparam int unsigned CW   = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int unsigned CMPW = 7;

    t_state                    r_state, n_state;
    t_op                       r_op;
    logic [2:0]                r_bit;
    logic [MAX_CODE_BITS-1:0]  r_acc;
    logic [CNTW-1:0]           r_cnt;
    logic [AW-1:0]             r_idx;
    logic [TOTAL_W-1:0]        r_emitted;
    logic [3:0]                r_runs;
    logic                      r_pend_v;
    t_res                      r_pend;
    logic                      r_out_v;
    t_res                      r_out;
    t_entry                    r_mem [MAX_ENTRIES];
    t_entry                    r_rd;

    logic [SCNT_W-1:0]  used;
    logic               finished;
    logic               out_free;
    logic               can_emit;
    logic               hit_ok;
    logic               more;
    logic               overflow;
    logic               run_end;
    logic               pop;
    logic               mem_we;
    logic               emit_hit;
    logic               emit_err;
    logic               emit_run;
    logic               emit;
    logic               step_bit;
    logic               flush_push;
    logic               out_push;
    logic [AW-1:0]      rd_addr;
    logic [TOTAL_W-1:0] emitted_inc;
    t_res               new_res;
    t_res               push_res;

    assign used = (i_symbol_count > SCNT_W'(MAX_ENTRIES)) ? SCNT_W'(MAX_ENTRIES)
                                                           : i_symbol_count;
    assign finished = (r_emitted >= i_total_symbols);
    assign out_free = !r_out_v || o_out.ready;
    // A new result parks in the pending slot, so the older one must be able to leave.
    assign can_emit = !r_pend_v || out_free;
    assign hit_ok   = (used != SCNT_W'(0))
                   && (CMPW'(r_rd.len) == CMPW'(r_cnt))
                   && (CW'(r_rd.code) == CW'(r_acc));
    assign more     = (SCNT_W'({1'b0, r_idx}) + SCNT_W'(1)) < used;
    assign overflow = (r_cnt >= CNTW'(MAX_CODE_BITS));
    assign run_end  = (r_runs == 4'(RUN_MAX)) || finished;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_data.kind)
                        K_DATA:  n_state = S_SHIFT;
                        K_RUN:   n_state = S_RUN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SHIFT: begin
                n_state = finished ? S_FLUSH : S_CMP;
            end
            S_CMP: begin
                if (step_bit) begin
                    n_state = (r_bit == 3'd0) ? S_FLUSH : S_SHIFT;
                end
            end
            S_RUN: begin
                if (run_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop        = (r_state == S_IDLE) && i_q_valid;
        mem_we     = pop && (i_q_data.kind == K_LOAD);
        emit_hit   = (r_state == S_CMP) && hit_ok && can_emit;
        emit_err   = (r_state == S_CMP) && !hit_ok && !more && overflow && can_emit;
        emit_run   = (r_state == S_RUN) && !run_end && can_emit;
        emit       = emit_hit || emit_err || emit_run;
        step_bit   = (r_state == S_CMP)
                  && ((hit_ok && can_emit) || (!hit_ok && !more && (!overflow || can_emit)));
        flush_push = (r_state == S_FLUSH) && r_pend_v && out_free;
        out_push   = (emit && r_pend_v) || flush_push;
        if ((r_state == S_CMP) && !hit_ok && more) begin
            rd_addr = r_idx + AW'(1);
        end else if (r_state == S_CMP) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = '0;
        end
    end

    assign emitted_inc         = r_emitted + TOTAL_W'(emit_hit || emit_run);
    assign new_res.symbol      = emit_err ? '0 : r_rd.sym;
    assign new_res.last        = 1'b0;
    assign new_res.done_res    = (emitted_inc >= i_total_symbols);
    assign new_res.code_error  = emit_err;
    assign push_res.symbol     = r_pend.symbol;
    assign push_res.last       = flush_push;
    assign push_res.done_res   = r_pend.done_res;
    assign push_res.code_error = r_pend.code_error;

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_data.idx[AW-1:0]] <= '{sym: i_q_data.sym, len: i_q_data.len,
                                             code: i_q_data.code};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op <= i_q_data;
        end
        if (pop) begin
            r_bit <= 3'd7;
        end else if (step_bit) begin
            r_bit <= r_bit - 3'd1;
        end
        if (r_state == S_SHIFT) begin
            r_idx <= '0;
        end else if ((r_state == S_CMP) && !hit_ok && more) begin
            r_idx <= r_idx + AW'(1);
        end
        if (pop) begin
            r_runs <= '0;
        end else if (emit_run) begin
            r_runs <= r_runs + 4'd1;
        end
        if (emit) begin
            r_pend <= new_res;
        end
        if (out_push) begin
            r_out <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_emitted <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_emitted <= emitted_inc;
            if ((r_state == S_SHIFT) && !finished) begin
                r_acc <= {r_acc[MAX_CODE_BITS-2:0], r_op.data_byte[r_bit]};
                r_cnt <= r_cnt + CNTW'(1);
            end else if (step_bit && (hit_ok || overflow)) begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (flush_push) begin
                r_pend_v <= 1'b0;
            end
            if (out_push) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.symbol     = r_out.symbol;
    assign o_out.last       = r_out.last;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.code_error = r_out.code_error;
endmodule
`default_nettype wire

// ===== rtl/prefix_code_table_decoder_unit.sv =====
// Top level of the prefix code table decoder.
//
//  Channel  | Dir | Beat contents
//  ---------+-----+--------------------------------------------------------
//  i_in     | in  | command, table entry fields, compressed data byte
//  o_out    | out | symbol, last, done_res, code_error
//  i_cfg_*  | in  | register write: symbol_count (0), total_symbols (1)
//
// Until finished, each data byte bit, MSB first, is shifted into the accumulator
// and compared against table entries one at a time (at least one, at most those in
// use, stopping at the first match); the table memory gives one entry per cycle.
// A run emits the symbol of entry 0 up to RUN_MAX times. Loads go into the table
// memory as the engine takes them. Reset is synchronous and empties the queue, the
// accumulator and the emitted count; table contents stay undefined until loaded.
// The output stage holds one pending and one registered result; a stalled output
// stops the engine, and the two-entry queue then stops input beats.
`timescale 1ns / 1ps
`default_nettype none
module prefix_code_table_decoder_unit
    import pfx_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES   = 256,
    parameter int unsigned MAX_CODE_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    pfx_in_if.sink                i_in,
    pfx_out_if.source             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    logic [SCNT_W-1:0]  r_symbol_count;
    logic [TOTAL_W-1:0] r_total_symbols;
    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    t_op                q_in;
    t_op                q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count  <= SCNT_W'(1);
            r_total_symbols <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SYMBOL_COUNT:  r_symbol_count  <= i_cfg_data[SCNT_W-1:0];
                REG_TOTAL_SYMBOLS: r_total_symbols <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    pfx_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .i_in           (i_in),
        .i_symbol_count (r_symbol_count),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    pfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    pfx_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_out),
        .o_q_pop         (q_pop),
        .i_symbol_count  (r_symbol_count),
        .i_total_symbols (r_total_symbols),
        .o_out           (o_out)
    );

    // An error result never carries a symbol value.
    a_err_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.code_error |-> o_out.symbol == '0)
        else $error("error beat with nonzero symbol");

    // Errors only occur while decoding is still running.
    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.code_error |-> !o_out.done_res)
        else $error("error beat after decoding finished");

    // Nothing is presented right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output beat right after reset");
endmodule
`default_nettype wire

// ===== tb/prefix_code_table_decoder_unit_tb.sv =====
// Self-checking testbench for the prefix code table decoder: table loads, bit decoding and runs.
`timescale 1ns / 1ps
`default_nettype none
module prefix_code_table_decoder_unit_tb;
    import pfx_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Up to three items can sit in the engine and queue with no result to show for them.
    localparam int DRAIN_CYCLES = 3 * (8 * (2 + 256) + 2) + 64;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  idx;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] data_byte;
    } cmd_beat_t;

    class decode_scoreboard;
        logic [SYM_W-1:0]   sym_tab[256];
        logic [LEN_W-1:0]   len_tab[256];
        logic [CODE_W-1:0]  code_tab[256];
        logic [CODE_W-1:0]  acc;
        logic [LEN_W-1:0]   nbits;
        logic [31:0]        emitted;
        logic [SCNT_W-1:0]  scount;
        logic [TOTAL_W-1:0] total;
        t_res               want_q[$];
        int                 errors;

        function new();
            acc = '0;
            nbits = '0;
            emitted = '0;
            scount = SCNT_W'(1);
            total = '0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] d);
            if (idx == REG_SYMBOL_COUNT) scount = d[SCNT_W-1:0];
            else total = d;
        endfunction

        function void push_symbol(logic [SYM_W-1:0] s, logic err);
            t_res r;
            r.symbol = s;
            r.last = 1'b0;
            r.done_res = (emitted >= total);
            r.code_error = err;
            want_q.push_back(r);
        endfunction

        function void note_beat(cmd_beat_t b);
            int start;
            int used;
            int i;
            bit hit;
            start = want_q.size();
            used = (scount > 256) ? 256 : int'(scount);
            case (b.command)
                CMD_LOAD: begin
                    sym_tab[b.idx] = b.sym;
                    len_tab[b.idx] = b.len;
                    code_tab[b.idx] = b.code;
                end
                CMD_DATA: begin
                    if (scount != 1) begin
                        for (int k = 7; k >= 0; k--) begin
                            if (emitted >= total) break;
                            acc = {acc[CODE_W-2:0], b.data_byte[k]};
                            nbits++;
                            hit = 0;
                            for (i = 0; i < used; i++) begin
                                if (len_tab[i] == nbits && code_tab[i] == acc) begin
                                    emitted++;
                                    push_symbol(sym_tab[i], 1'b0);
                                    hit = 1;
                                    break;
                                end
                            end
                            if (hit || nbits >= 32) begin
                                if (!hit) push_symbol('0, 1'b1);
                                acc = '0;
                                nbits = '0;
                            end
                        end
                    end
                end
                CMD_RUN: begin
                    if (scount == 1) begin
                        for (i = 0; i < RUN_MAX && emitted < total; i++) begin
                            emitted++;
                            push_symbol(sym_tab[0], 1'b0);
                        end
                    end
                end
                default: ;
            endcase
            if (want_q.size() > start) want_q[$].last = 1'b1;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected beat symbol=%02h", got.symbol));
            end else begin
                want = want_q.pop_front();
                if (got.symbol !== want.symbol)
                    report($sformatf("symbol %02h, want %02h", got.symbol, want.symbol));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
                if (got.done_res !== want.done_res)
                    report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
                if (got.code_error !== want.code_error)
                    report($sformatf("code_error %b, want %b", got.code_error, want.code_error));
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    pfx_in_if  in_if();
    pfx_out_if out_if();

    prefix_code_table_decoder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    decode_scoreboard sb = new();

    int send_pct = 0;
    int stall_pct = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int tb_len[256];
    logic [CODE_W-1:0] tb_code[256];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.symbol, out_if.last, out_if.done_res, out_if.code_error});
    end

    task automatic send(cmd_beat_t b);
        while ($urandom_range(99) < send_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.command      <= b.command;
        in_if.entry_index  <= b.idx;
        in_if.entry_symbol <= b.sym;
        in_if.entry_length <= b.len;
        in_if.entry_code   <= b.code;
        in_if.data_byte    <= b.data_byte;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_beat(b);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly short well-formed codes; now and then odd lengths or stray high code bits.
    function automatic cmd_beat_t make_entry(int idx);
        cmd_beat_t b;
        int r;
        b = cmd_beat_t'({$urandom, $urandom});
        b.command = CMD_LOAD;
        b.idx = IDX_W'(idx);
        r = $urandom_range(99);
        if (r < 8) begin
            b.len = LEN_W'($urandom_range(0, 63));
            b.code = $urandom;
        end else begin
            b.len = LEN_W'($urandom_range(1, 7));
            b.code = $urandom & ((32'd1 << b.len) - 1);
            if (r < 16) b.code = b.code | (32'd1 << b.len);
        end
        tb_len[idx] = int'(b.len);
        tb_code[idx] = b.code;
        return b;
    endfunction

    task automatic run_phase(int scnt, logic [31:0] total, int nbytes, int spct, int rpct,
                             bit hold);
        int n;
        int nload;
        int pick;
        int r;
        bit bits[$];
        cmd_beat_t b;
        wait_idle();
        send_pct = spct;
        stall_pct = rpct;
        cfg_write(REG_SYMBOL_COUNT, scnt);
        cfg_write(REG_TOTAL_SYMBOLS, total);
        n = (scnt > 256) ? 256 : scnt;
        nload = (n == 0) ? 1 : n;
        for (int i = 0; i < nload; i++) send(make_entry(i));
        if (hold) hold_req = 1;
        // Build a bit stream that is mostly back-to-back valid codes.
        while (bits.size() < 8 * nbytes) begin
            pick = (n > 0) ? $urandom_range(n - 1) : 0;
            if (n > 0 && $urandom_range(99) < 85 && tb_len[pick] >= 1 && tb_len[pick] <= 32
                && (tb_len[pick] == 32 || (tb_code[pick] >> tb_len[pick]) == 0)) begin
                for (int j = tb_len[pick] - 1; j >= 0; j--) bits.push_back(tb_code[pick][j]);
            end else begin
                bits.push_back(bit'($urandom_range(1)));
            end
        end
        for (int k = 0; k < nbytes; k++) begin
            b = cmd_beat_t'({$urandom, $urandom});
            for (int j = 7; j >= 0; j--) b.data_byte[j] = bits.pop_front();
            r = $urandom_range(99);
            if (scnt == 1) begin
                b.command = (r < 70) ? CMD_RUN : (r < 85) ? CMD_DATA : CMD_UNUSED;
            end else if (r < 90) begin
                b.command = CMD_DATA;
            end else if (r < 94) begin
                b = make_entry($urandom_range(nload - 1));
            end else begin
                b.command = (r < 97) ? CMD_RUN : CMD_UNUSED;
            end
            send(b);
        end
    endtask

    initial begin
        cmd_beat_t b;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_SYMBOL_COUNT;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.command = CMD_LOAD;
        in_if.entry_index = '0;
        in_if.entry_symbol = '0;
        in_if.entry_length = '0;
        in_if.entry_code = '0;
        in_if.data_byte = '0;
        out_if.ready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset state: single-symbol mode, nothing to emit; none of these yields a result.
        b = '{CMD_LOAD, 8'd0, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF};
        send(b);
        b.command = CMD_UNUSED;
        send(b);
        b.command = CMD_RUN;
        send(b);
        b.command = CMD_DATA;
        send(b);

        run_phase(1, 32'd0, 2, 0, 0, 0);
        run_phase(1, 32'd21, 6, 6, 6, 0);
        run_phase(4, 32'hFFFF_FFFF, 12, 0, 0, 0);
        run_phase(12, 32'hFFFF_FFFF, 16, 58, 0, 0);
        run_phase(6, 32'hFFFF_FFFF, 24, 0, 58, 1);
        run_phase(0, 32'hFFFF_FFFF, 8, 6, 6, 0);
        run_phase(511, 32'hFFFF_FFFF, 3, 6, 6, 0);
        run_phase(8, 32'd30, 10, 6, 6, 0);
        run_phase(2, 32'hFFFF_FFFF, 12, 58, 58, 0);
        run_phase(3, 32'd1, 4, 0, 0, 0);

        wait_idle();
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/pfx_pkg.sv
rtl/pfx_in_if.sv
rtl/pfx_out_if.sv
rtl/pfx_front.sv
rtl/pfx_queue.sv
rtl/pfx_back.sv
rtl/prefix_code_table_decoder_unit.sv
tb/prefix_code_table_decoder_unit_tb.sv
